/* hw/rtl/bdq_pkg.sv */
package bdq_pkg;

  // Storage size and derived widths.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 7;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

  // Operation codes carried in the request.
  localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_POP_BACK   = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;
    logic load_pop;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_busy;
    logic needs_read;
  } dp_stat_t;

endpackage

/* hw/rtl/byte_deque.sv */
// Channel   Direction  Content
// s_axis    in         request: operation, letter
// m_axis    out        result: popped_byte, status, count
//
// A push, or a pop on an empty queue, writes the output register directly; a
// pop that returns a byte first passes the byte store's registered read port.
// The result sits in an output register, so the next request is taken at the
// edge where the previous result leaves. Reset empties the queue at once.
// A stalled result holds the input side until it is taken.
module byte_deque (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [1:0] operation, [9:2] letter, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [7:0] popped_byte, [9:8] status,
                                      // [16:10] count, zero pad
);
  import bdq_pkg::*;

  ctl_cmd_t   cmd;
  dp_stat_t   stat;
  logic [7:0] popped_byte;
  logic [1:0] status;
  logic [6:0] count;

  bdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bdq_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .operation_i   (s_axis_tdata[1:0]),
    .letter_i      (s_axis_tdata[9:2]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .popped_byte_o (popped_byte),
    .status_o      (status),
    .count_o       (count)
  );

  assign m_axis_tdata = {7'd0, count, status, popped_byte};

endmodule

/* hw/rtl/bdq_datapath.sv */
module bdq_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bdq_pkg::ctl_cmd_t cmd_i,
  output bdq_pkg::dp_stat_t stat_o,
  input  logic [1:0]        operation_i,
  input  logic [7:0]        letter_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [7:0]        popped_byte_o,
  output logic [1:0]        status_o,
  output logic [6:0]        count_o
);
  import bdq_pkg::*;

  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q;
  logic [7:0]       popped_q;
  logic [1:0]       status_q, status_d;
  logic [CNT_W-1:0] out_count_q;
  logic [7:0]       mem [CAPACITY];
  logic [7:0]       rd_data_q;

  logic             is_pop, is_empty, is_full;
  logic [IDX_W-1:0] front_dec, front_inc, back_pos, last_pos;
  logic [IDX_W:0]   back_sum, last_sum;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] wr_addr, rd_addr;

  // Circular index arithmetic.
  always_comb begin
    front_dec = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
    front_inc = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;
    back_sum  = {1'b0, front_q} + (IDX_W + 1)'(count_q);
    back_pos  = (back_sum >= (IDX_W + 1)'(CAPACITY)) ?
                IDX_W'(back_sum - (IDX_W + 1)'(CAPACITY)) : IDX_W'(back_sum);
    last_sum  = back_sum - 1'b1;
    last_pos  = (last_sum >= (IDX_W + 1)'(CAPACITY)) ?
                IDX_W'(last_sum - (IDX_W + 1)'(CAPACITY)) : IDX_W'(last_sum);
  end

  // Decode the request and work out the next queue state.
  always_comb begin
    is_pop   = operation_i[1];
    is_empty = (count_q == '0);
    is_full  = (count_q >= CAP_COUNT);
    front_d  = front_q;
    count_d  = count_q;
    status_d = STAT_OK;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    wr_addr  = back_pos;
    rd_addr  = front_q;
    case (operation_i)
      OP_PUSH_FRONT: begin
        if (is_full) begin
          status_d = STAT_FULL;
        end else begin
          front_d = front_dec;
          count_d = count_q + 1'b1;
          wr_addr = front_dec;
          mem_we  = cmd_i.exec;
        end
      end
      OP_PUSH_BACK: begin
        if (is_full) begin
          status_d = STAT_FULL;
        end else begin
          count_d = count_q + 1'b1;
          mem_we  = cmd_i.exec;
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          status_d = STAT_EMPTY;
        end else begin
          front_d = front_inc;
          count_d = count_q - 1'b1;
          mem_re  = cmd_i.exec;
        end
      end
      OP_POP_BACK: begin
        if (is_empty) begin
          status_d = STAT_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
          rd_addr = last_pos;
          mem_re  = cmd_i.exec;
        end
      end
      default: begin
        status_d = STAT_OK;
      end
    endcase
  end

  assign stat_o.out_busy   = out_valid_q & ~out_ready_i;
  assign stat_o.needs_read = is_pop & ~is_empty;

  // Byte store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= letter_i;
    end
    if (mem_re) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  // Output register; a pop result gets its byte in the cycle after the read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_pop || (cmd_i.exec && !stat_o.needs_read)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      popped_q    <= '0;
      status_q    <= status_d;
      out_count_q <= count_d;
    end else if (cmd_i.load_pop) begin
      popped_q <= rd_data_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign popped_byte_o = popped_q;
  assign status_o      = status_q;
  assign count_o       = out_count_q;

endmodule

/* hw/rtl/bdq_ctrl.sv */
module bdq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bdq_pkg::dp_stat_t stat_i,
  output bdq_pkg::ctl_cmd_t cmd_o
);
  import bdq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_q, state_d;

  // Take a request when idle and the output register is free at this edge.
  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.exec     = 1'b0;
    cmd_o.load_pop = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = ~stat_i.out_busy;
        cmd_o.exec = in_valid_i & ~stat_i.out_busy;
        if (cmd_o.exec && stat_i.needs_read) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.load_pop = 1'b1;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
